@@ rtl/core/cslex_pkg.sv @@
// ----------------------------------------------------------------------------
// cslex_pkg
// Shared types, character classes and the keyword table of the C lexer.
// ----------------------------------------------------------------------------
package cslex_pkg;

  localparam int MAX_KEYWORD_LEN_DEF = 8;
  localparam int KW_BITS             = 64;
  localparam int KW_COUNT            = 31;
  localparam int QDEPTH              = 4;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_WORD       = 3'd1,
    MODE_NUMBER     = 3'd2,
    MODE_SLASH      = 3'd3,
    MODE_OP         = 3'd4,
    MODE_LINE_CMT   = 3'd5,
    MODE_BLOCK_CMT  = 3'd6,
    MODE_BLOCK_STAR = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    CLS_IDENT   = 3'd0,
    CLS_KEYWORD = 3'd1,
    CLS_INTEGER = 3'd2,
    CLS_DELIM   = 3'd3,
    CLS_OPER    = 3'd4,
    CLS_UNKNOWN = 3'd5
  } tok_class_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  plen;
    logic [7:0]  pfirst;
    logic [7:0]  psecond;
    logic [15:0] line_cnt;
    logic [31:0] offset;
    logic [31:0] tstart;
  } lex_state_t;

  typedef struct packed {
    tok_class_t  token_class;
    logic [7:0]  token_length;
    logic [15:0] line_number;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [31:0] start_offset;
    logic        last_of_run;
  } tok_t;

  localparam logic [KW_BITS-1:0] KW_WORD [KW_COUNT] = '{
    "if", "else", "while", "for", "return", "continue", "do", "goto",
    "case", "break", "default", "switch", "enum", "extern", "sizeof",
    "static", "union", "unsigned", "struct", "volatile", "int", "double",
    "float", "char", "void", "long", "short", "true", "NULL", "false",
    "typedef"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd8, 4'd2, 4'd4,
    4'd4, 4'd5, 4'd7, 4'd6, 4'd4, 4'd6, 4'd6,
    4'd6, 4'd5, 4'd8, 4'd6, 4'd8, 4'd3, 4'd6,
    4'd5, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5,
    4'd7
  };

  function automatic logic [KW_BITS-1:0] kw_mask(input logic [3:0] len);
    logic [KW_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < KW_BITS / 8; b++) begin
      if (4'(b) < len) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_skip(input logic [7:0] c);
    return c inside {CH_SEMI, CH_SPACE, CH_TAB, CH_NL};
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2E, 8'h3F, 8'h2C};
  endfunction

  function automatic logic is_opstart(input logic [7:0] c);
    return c inside {8'h3D, 8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2A, 8'h3A};
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    return (b == CH_EQ && (a inside {8'h3D, 8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2A}))
        || (a == 8'h2B && b == 8'h2B) || (a == 8'h2D && b == 8'h2D)
        || (a == 8'h2D && b == 8'h3E) || (a == 8'h3A && b == 8'h3A);
  endfunction

endpackage

@@ rtl/core/cslex_in_if.sv @@
// ----------------------------------------------------------------------------
// cslex_in_if
// Source byte channel: one character word per handshake.
// ----------------------------------------------------------------------------
interface cslex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source(output valid, char_byte, end_of_input, input ready);
  modport sink(input valid, char_byte, end_of_input, output ready);
endinterface

@@ rtl/core/cslex_out_if.sv @@
// ----------------------------------------------------------------------------
// cslex_out_if
// Token channel: one token word per handshake.
// ----------------------------------------------------------------------------
interface cslex_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_class;
  logic [7:0]  token_length;
  logic [15:0] line_number;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic [31:0] start_offset;
  logic        last_of_run;

  modport source(output valid, token_class, token_length, line_number, first_char,
                 second_char, start_offset, last_of_run, input ready);
  modport sink(input valid, token_class, token_length, line_number, first_char,
               second_char, start_offset, last_of_run, output ready);
endinterface

@@ rtl/core/cslex_kw_match.sv @@
// ----------------------------------------------------------------------------
// cslex_kw_match
// Parallel compare of the word window against the keyword table.
// ----------------------------------------------------------------------------
module cslex_kw_match #(
  parameter int WIN_W = 8 * cslex_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic [WIN_W-1:0] win,
  input  logic [7:0]       plen,
  output logic             hit
);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < cslex_pkg::KW_COUNT; i++) begin
      if (plen == {4'd0, cslex_pkg::KW_LEN[i]} &&
          (win[cslex_pkg::KW_BITS-1:0] & cslex_pkg::kw_mask(cslex_pkg::KW_LEN[i]))
            == cslex_pkg::KW_WORD[i]) begin
        hit = 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/cslex_step.sv @@
// ----------------------------------------------------------------------------
// cslex_step
// Next-state and token logic for one accepted word.
// ----------------------------------------------------------------------------
module cslex_step #(
  parameter int WIN_W = 8 * cslex_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  cslex_pkg::lex_state_t st,
  input  logic [WIN_W-1:0]      win,
  input  logic                  kw_hit,
  input  logic [7:0]            char_byte,
  input  logic                  end_of_input,
  output cslex_pkg::lex_state_t st_nxt,
  output logic [WIN_W-1:0]      win_nxt,
  output cslex_pkg::tok_t       tok0,
  output cslex_pkg::tok_t       tok1,
  output logic [1:0]            tok_count
);

  cslex_pkg::tok_t fl_tok;
  cslex_pkg::tok_t ft;
  cslex_pkg::tok_t it;
  logic            fl_valid;
  logic            fv;
  logic            iv;
  logic            reidle;
  logic [7:0]      c;
  logic [15:0]     line_inc;

  assign c        = char_byte;
  assign line_inc = (st.line_cnt != 16'hFFFF) ? st.line_cnt + 16'd1 : st.line_cnt;

  always_comb begin
    fl_tok              = '0;
    fl_tok.line_number  = st.line_cnt;
    fl_tok.first_char   = st.pfirst;
    fl_tok.start_offset = st.tstart;
    fl_valid            = 1'b0;
    case (st.mode)
      cslex_pkg::MODE_WORD: begin
        fl_valid            = 1'b1;
        fl_tok.token_class  = kw_hit ? cslex_pkg::CLS_KEYWORD : cslex_pkg::CLS_IDENT;
        fl_tok.token_length = st.plen;
        fl_tok.second_char  = st.psecond;
      end
      cslex_pkg::MODE_NUMBER: begin
        fl_valid            = 1'b1;
        fl_tok.token_class  = cslex_pkg::CLS_INTEGER;
        fl_tok.token_length = st.plen;
        fl_tok.second_char  = st.psecond;
      end
      cslex_pkg::MODE_SLASH, cslex_pkg::MODE_OP: begin
        fl_valid            = 1'b1;
        fl_tok.token_class  = cslex_pkg::CLS_OPER;
        fl_tok.token_length = 8'd1;
      end
      default: fl_valid = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt  = st;
    win_nxt = win;
    reidle  = 1'b0;
    fv      = 1'b0;
    iv      = 1'b0;
    ft      = fl_tok;
    it                = '0;
    it.line_number    = st.line_cnt;
    it.token_length   = 8'd1;
    it.first_char     = c;
    it.start_offset   = st.offset;
    it.token_class    = cslex_pkg::CLS_UNKNOWN;

    if (end_of_input) begin
      fv          = fl_valid;
      st_nxt.mode = cslex_pkg::MODE_IDLE;
    end else begin
      case (st.mode)
        cslex_pkg::MODE_WORD, cslex_pkg::MODE_NUMBER: begin
          if (cslex_pkg::is_digit(c) ||
              (st.mode == cslex_pkg::MODE_WORD && cslex_pkg::is_letter(c))) begin
            if (st.plen == 8'd1) st_nxt.psecond = c;
            if (st.plen != 8'hFF) st_nxt.plen = st.plen + 8'd1;
            win_nxt = {win[WIN_W-9:0], c};
          end else begin
            fv     = 1'b1;
            reidle = 1'b1;
          end
        end
        cslex_pkg::MODE_SLASH: begin
          if (c == cslex_pkg::CH_EQ) begin
            fv              = 1'b1;
            ft.token_length = 8'd2;
            ft.second_char  = c;
            st_nxt.mode     = cslex_pkg::MODE_IDLE;
          end else if (c == cslex_pkg::CH_SLASH) begin
            st_nxt.mode = cslex_pkg::MODE_LINE_CMT;
          end else if (c == cslex_pkg::CH_STAR) begin
            st_nxt.mode = cslex_pkg::MODE_BLOCK_CMT;
          end else begin
            fv     = 1'b1;
            reidle = 1'b1;
          end
        end
        cslex_pkg::MODE_OP: begin
          fv = 1'b1;
          if (cslex_pkg::is_pair(st.pfirst, c)) begin
            ft.token_length = 8'd2;
            ft.second_char  = c;
            st_nxt.mode     = cslex_pkg::MODE_IDLE;
          end else begin
            reidle = 1'b1;
          end
        end
        cslex_pkg::MODE_LINE_CMT: begin
          if (c == cslex_pkg::CH_NL) begin
            st_nxt.line_cnt = line_inc;
            st_nxt.mode     = cslex_pkg::MODE_IDLE;
          end
        end
        cslex_pkg::MODE_BLOCK_CMT: begin
          if (c == cslex_pkg::CH_NL) st_nxt.line_cnt = line_inc;
          else if (c == cslex_pkg::CH_STAR) st_nxt.mode = cslex_pkg::MODE_BLOCK_STAR;
        end
        cslex_pkg::MODE_BLOCK_STAR: begin
          if (c == cslex_pkg::CH_SLASH) begin
            st_nxt.mode = cslex_pkg::MODE_IDLE;
          end else if (c != cslex_pkg::CH_STAR) begin
            if (c == cslex_pkg::CH_NL) st_nxt.line_cnt = line_inc;
            st_nxt.mode = cslex_pkg::MODE_BLOCK_CMT;
          end
        end
        default: reidle = 1'b1;
      endcase

      // reprocess the byte from idle
      if (reidle) begin
        st_nxt.mode = cslex_pkg::MODE_IDLE;
        if (cslex_pkg::is_skip(c)) begin
          if (c == cslex_pkg::CH_NL) st_nxt.line_cnt = line_inc;
        end else if (cslex_pkg::is_letter(c) || cslex_pkg::is_digit(c) ||
                     c == cslex_pkg::CH_SLASH || cslex_pkg::is_opstart(c)) begin
          if (cslex_pkg::is_letter(c)) st_nxt.mode = cslex_pkg::MODE_WORD;
          else if (cslex_pkg::is_digit(c)) st_nxt.mode = cslex_pkg::MODE_NUMBER;
          else if (c == cslex_pkg::CH_SLASH) st_nxt.mode = cslex_pkg::MODE_SLASH;
          else st_nxt.mode = cslex_pkg::MODE_OP;
          st_nxt.plen    = 8'd1;
          st_nxt.pfirst  = c;
          st_nxt.psecond = 8'd0;
          st_nxt.tstart  = st.offset;
          win_nxt        = {{(WIN_W-8){1'b0}}, c};
        end else begin
          iv = 1'b1;
          if (cslex_pkg::is_delim(c)) it.token_class = cslex_pkg::CLS_DELIM;
        end
      end

      if (st.offset != 32'hFFFF_FFFF) st_nxt.offset = st.offset + 32'd1;
    end
  end

  always_comb begin
    tok0             = fv ? ft : it;
    tok0.last_of_run = !(fv && iv);
    tok1             = it;
    tok1.last_of_run = 1'b1;
    tok_count        = {1'b0, fv} + {1'b0, iv};
  end

endmodule

@@ rtl/core/cslex_out_queue.sv @@
// ----------------------------------------------------------------------------
// cslex_out_queue
// Small token queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module cslex_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_count,
  input  cslex_pkg::tok_t tok0,
  input  cslex_pkg::tok_t tok1,
  input  logic            pop,
  output cslex_pkg::tok_t head,
  output logic            head_valid,
  output logic            room2
);

  localparam int PTR_W = $clog2(cslex_pkg::QDEPTH);
  localparam int CNT_W = $clog2(cslex_pkg::QDEPTH + 1);

  cslex_pkg::tok_t   mem_r [cslex_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [PTR_W-1:0]  wr_ptr_p1;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign room2      = (count_r <= CNT_W'(cslex_pkg::QDEPTH - 2));
  assign wr_ptr_p1  = PTR_W'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = PTR_W'(wr_ptr_r + PTR_W'(push_count));
  assign rd_ptr_nxt = PTR_W'(rd_ptr_r + PTR_W'(pop));
  assign count_nxt  = CNT_W'(count_r + CNT_W'(push_count) - CNT_W'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem_r[wr_ptr_r] <= tok0;
    if (push_count == 2'd2) mem_r[wr_ptr_p1] <= tok1;
  end

endmodule

@@ rtl/core/c_source_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// c_source_lexer_unit
// Lexical scanner for C source text, one character word per cycle while the token queue has room.
// ----------------------------------------------------------------------------
// Feed source bytes on in_ch; tokens leave on out_ch with class, length,
// line, first two characters and start offset. Set end_of_input on a word
// to flush the pending token; its byte is ignored.
// A word causes zero, one or two tokens; last_of_run marks the final token
// of each word. Tokens reach out_ch through the registered queue once the
// word that causes them is taken.
// Throughput: one byte per cycle while tokens drain at least as fast as they
// are made. Tokens pass through a four-entry queue; in_ch.ready is high while
// the queue has two free entries, so a stalled receiver holds the input only
// once fewer than two entries are free, and a word that yields two tokens
// costs two output handshakes.
// Reset (rst_n low, synchronous) returns the scanner to idle, line counter to
// one, offset to zero, and empties the queue.
// ----------------------------------------------------------------------------
module c_source_lexer_unit #(
  parameter int MAX_KEYWORD_LEN = cslex_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cslex_in_if.sink    in_ch,
  cslex_out_if.source out_ch
);

  localparam int WIN_W = 8 * MAX_KEYWORD_LEN;

  cslex_pkg::lex_state_t st_r;
  cslex_pkg::lex_state_t st_nxt;
  logic [WIN_W-1:0]      win_r;
  logic [WIN_W-1:0]      win_nxt;
  logic                  kw_hit;
  cslex_pkg::tok_t       tok0;
  cslex_pkg::tok_t       tok1;
  cslex_pkg::tok_t       head;
  logic [1:0]            tok_count;
  logic [1:0]            push_count;
  logic                  accept;
  logic                  room2;
  logic                  head_valid;

  assign in_ch.ready = room2;
  assign accept      = in_ch.valid && room2;
  assign push_count  = accept ? tok_count : 2'd0;

  cslex_kw_match #(.WIN_W(WIN_W)) u_kw (
    .win  (win_r),
    .plen (st_r.plen),
    .hit  (kw_hit)
  );

  cslex_step #(.WIN_W(WIN_W)) u_step (
    .st           (st_r),
    .win          (win_r),
    .kw_hit       (kw_hit),
    .char_byte    (in_ch.char_byte),
    .end_of_input (in_ch.end_of_input),
    .st_nxt       (st_nxt),
    .win_nxt      (win_nxt),
    .tok0         (tok0),
    .tok1         (tok1),
    .tok_count    (tok_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= cslex_pkg::MODE_IDLE;
      st_r.plen     <= '0;
      st_r.pfirst   <= '0;
      st_r.psecond  <= '0;
      st_r.line_cnt <= 16'd1;
      st_r.offset   <= '0;
      st_r.tstart   <= '0;
      win_r         <= '0;
    end else if (accept) begin
      st_r  <= st_nxt;
      win_r <= win_nxt;
    end
  end

  cslex_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_count),
    .tok0       (tok0),
    .tok1       (tok1),
    .pop        (head_valid && out_ch.ready),
    .head       (head),
    .head_valid (head_valid),
    .room2      (room2)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.token_class  = head.token_class;
  assign out_ch.token_length = head.token_length;
  assign out_ch.line_number  = head.line_number;
  assign out_ch.first_char   = head.first_char;
  assign out_ch.second_char  = head.second_char;
  assign out_ch.start_offset = head.start_offset;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule
